@@ src/hks_pkg.sv @@
// hks_pkg: shared constants, register indexes, controller states and the
// command/status structs for the heap-based rank selector.
// No dependencies.
package hks_pkg;

   // Fixed field widths
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 8;
   localparam int RANK_W     = 7;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   // Default store size
   localparam int DEFAULT_STORE_DEPTH = 128;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ELEMENT_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANK          = 1'd1;

   // Register reset values
   localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RESET = 8'd100;
   localparam logic [RANK_W-1:0]  RANK_RESET          = 7'd10;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_BUILD_NEXT,
      ST_REMOVE_NEXT,
      ST_HELD_WAIT,
      ST_SIFT_TEST,
      ST_CHILD_L,
      ST_CHILD_R,
      ST_DECIDE,
      ST_READ_TOP,
      ST_TOP_WAIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic setup;
      logic build_read;
      logic remove_read;
      logic capture_held;
      logic read_left;
      logic capture_left;
      logic read_right;
      logic capture_right;
      logic write_held;
      logic write_cand;
      logic read_top;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic set_last;
      logic bld_zero;
      logic rem_zero;
      logic heap_end_zero;
      logic kid_gt_last;
      logic kid_lt_last;
      logic right_better;
      logic held_wins;
      logic rsp_free;
   } status_type;

endpackage

@@ src/hks_ram.sv @@
// hks_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module hks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/hks_datapath.sv @@
// hks_datapath: configuration registers, load counter, value store, heap
// index registers, comparators and the result register.
// Depends on hks_pkg and hks_ram.
module hks_datapath #(
   parameter int STORE_DEPTH = hks_pkg::DEFAULT_STORE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [hks_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hks_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic signed [hks_pkg::VALUE_W-1:0] req_sample_value,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic signed [hks_pkg::VALUE_W-1:0] rsp_selected_value,
   input  hks_pkg::cmd_type                 cmd,
   output hks_pkg::status_type              status
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int IW = ((AW > hks_pkg::COUNT_W) ? AW : hks_pkg::COUNT_W) + 2;
   localparam logic [IW-1:0] DEPTH_I = IW'(STORE_DEPTH);

   // Control registers
   logic [hks_pkg::COUNT_W-1:0] count_cfg_ff, count_cfg_in;
   logic [hks_pkg::RANK_W-1:0]  rank_cfg_ff, rank_cfg_in;
   logic [hks_pkg::COUNT_W-1:0] fill_ff, fill_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [hks_pkg::COUNT_W-1:0] n_ff, n_in;
   logic                        use_max_ff, use_max_in;
   logic [hks_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic [hks_pkg::COUNT_W-1:0] bld_ff, bld_in;
   logic [IW-1:0]               heap_end_ff, heap_end_in;
   logic [IW-1:0]               last_ff, last_in;
   logic [IW-1:0]               pos_ff, pos_in;
   logic [IW-1:0]               kid_ff, kid_in;
   logic [IW-1:0]               cand_idx_ff, cand_idx_in;
   logic signed [hks_pkg::VALUE_W-1:0] held_ff, held_in;
   logic signed [hks_pkg::VALUE_W-1:0] cand_ff, cand_in;
   logic signed [hks_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   // Derived values
   logic [hks_pkg::COUNT_W-1:0] n_eff;
   logic [hks_pkg::COUNT_W-1:0] wr_idx;
   logic [IW-1:0]               wr_idx_w;
   logic [hks_pkg::COUNT_W-1:0] rank_w;
   logic [hks_pkg::COUNT_W-1:0] k_sat;
   logic                        use_max_c;
   logic [hks_pkg::COUNT_W-1:0] k_eff;
   logic [IW-1:0]               bld_m1;
   logic [IW-1:0]               kid_p1;

   // RAM port signals
   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [hks_pkg::VALUE_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [IW-1:0]               ram_rd_idx;
   logic [hks_pkg::VALUE_W-1:0] ram_rd_data;
   logic signed [hks_pkg::VALUE_W-1:0] q;

   assign q = $signed(ram_rd_data);

   // Effective count: zero reads as one, large counts clamp to the store
   always_comb begin
      if (count_cfg_ff == '0) begin
         n_eff = hks_pkg::COUNT_W'(1);
      end else if (IW'(count_cfg_ff) > DEPTH_I) begin
         n_eff = DEPTH_I[hks_pkg::COUNT_W-1:0];
      end else begin
         n_eff = count_cfg_ff;
      end
   end

   // Load slot; a count lowered below the fill restarts at slot zero
   assign wr_idx   = (fill_ff >= n_eff) ? '0 : fill_ff;
   assign wr_idx_w = IW'(wr_idx);

   // Rank saturation and heap direction
   assign rank_w    = hks_pkg::COUNT_W'(rank_cfg_ff);
   assign k_sat     = (rank_w >= n_eff) ? (n_eff - 8'd1) : rank_w;
   assign use_max_c = (k_sat > (n_eff >> 1));
   assign k_eff     = use_max_c ? (n_eff - k_sat - 8'd1) : k_sat;

   assign bld_m1 = IW'(bld_ff) - IW'(1);
   assign kid_p1 = kid_ff + IW'(1);

   // Status toward the controller
   always_comb begin
      status.set_last      = ((9'(wr_idx) + 9'd1) == 9'(n_eff));
      status.bld_zero      = (bld_ff == '0);
      status.rem_zero      = (rem_ff == '0);
      status.heap_end_zero = (heap_end_ff == '0);
      status.kid_gt_last   = (kid_ff > last_ff);
      status.kid_lt_last   = (kid_ff < last_ff);
      status.right_better  = use_max_ff ? (cand_ff < q) : (cand_ff > q);
      status.held_wins     = use_max_ff ? (held_ff >= cand_ff) : (held_ff <= cand_ff);
      status.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   // Store write port
   always_comb begin
      ram_wr_en = cmd.load_item || cmd.write_held || cmd.write_cand;
      if (cmd.load_item) begin
         ram_wr_addr = wr_idx_w[AW-1:0];
         ram_wr_data = req_sample_value;
      end else if (cmd.write_held) begin
         ram_wr_addr = pos_ff[AW-1:0];
         ram_wr_data = held_ff;
      end else begin
         ram_wr_addr = pos_ff[AW-1:0];
         ram_wr_data = cand_ff;
      end
   end

   // Store read port
   always_comb begin
      ram_rd_en = cmd.build_read || cmd.remove_read || cmd.read_left ||
                  cmd.read_right || cmd.read_top;
      if (cmd.build_read) begin
         ram_rd_idx = bld_m1;
      end else if (cmd.remove_read) begin
         ram_rd_idx = heap_end_ff;
      end else if (cmd.read_left) begin
         ram_rd_idx = kid_ff;
      end else if (cmd.read_right) begin
         ram_rd_idx = kid_p1;
      end else begin
         ram_rd_idx = '0;
      end
   end

   hks_ram #(
      .WIDTH (hks_pkg::VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_idx[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Control next values
   always_comb begin
      count_cfg_in = count_cfg_ff;
      rank_cfg_in  = rank_cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            hks_pkg::REG_ELEMENT_COUNT: count_cfg_in = csr_wdata;
            hks_pkg::REG_RANK:          rank_cfg_in  = csr_wdata[hks_pkg::RANK_W-1:0];
            default: ;
         endcase
      end
      fill_in = fill_ff;
      if (cmd.load_item) begin
         fill_in = status.set_last ? '0 : (wr_idx + 8'd1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Payload next values
   always_comb begin
      n_in        = n_ff;
      use_max_in  = use_max_ff;
      rem_in      = rem_ff;
      bld_in      = bld_ff;
      heap_end_in = heap_end_ff;
      last_in     = last_ff;
      pos_in      = pos_ff;
      kid_in      = kid_ff;
      cand_idx_in = cand_idx_ff;
      held_in     = held_ff;
      cand_in     = cand_ff;
      rsp_value_in = rsp_value_ff;
      if (cmd.setup) begin
         n_in        = n_eff;
         use_max_in  = use_max_c;
         rem_in      = k_eff;
         bld_in      = n_eff >> 1;
         heap_end_in = IW'(n_eff) - IW'(1);
      end
      // next build sift starts at the next lower parent
      if (cmd.build_read) begin
         pos_in  = bld_m1;
         kid_in  = {bld_m1[IW-2:0], 1'b1};
         last_in = IW'(n_ff) - IW'(1);
         bld_in  = bld_ff - 8'd1;
      end
      // removal: last entry becomes the held value, heap shrinks by one
      if (cmd.remove_read) begin
         pos_in      = '0;
         kid_in      = IW'(1);
         last_in     = heap_end_ff - IW'(1);
         heap_end_in = heap_end_ff - IW'(1);
         rem_in      = rem_ff - 8'd1;
      end
      if (cmd.capture_held) begin
         held_in = q;
      end
      if (cmd.capture_left) begin
         cand_in     = q;
         cand_idx_in = kid_ff;
      end
      if (cmd.capture_right) begin
         cand_in     = q;
         cand_idx_in = kid_p1;
      end
      // child moves up, descend one level
      if (cmd.write_cand) begin
         pos_in = cand_idx_ff;
         kid_in = {cand_idx_ff[IW-2:0], 1'b1};
      end
      if (cmd.load_rsp) begin
         rsp_value_in = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_cfg_ff <= hks_pkg::ELEMENT_COUNT_RESET;
         rank_cfg_ff  <= hks_pkg::RANK_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_cfg_ff <= count_cfg_in;
         rank_cfg_ff  <= rank_cfg_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      use_max_ff   <= use_max_in;
      rem_ff       <= rem_in;
      bld_ff       <= bld_in;
      heap_end_ff  <= heap_end_in;
      last_ff      <= last_in;
      pos_ff       <= pos_in;
      kid_ff       <= kid_in;
      cand_idx_ff  <= cand_idx_in;
      held_ff      <= held_in;
      cand_ff      <= cand_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_value = rsp_value_ff;

endmodule

@@ src/hks_ctrl.sv @@
// hks_ctrl: controller state machine that sequences load, heap build,
// removals and result hand-off.
// Depends on hks_pkg.
module hks_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hks_pkg::status_type  status,
   output hks_pkg::cmd_type     cmd,
   output hks_pkg::state_type   fsm_state
);

   hks_pkg::state_type state_ff, state_in;
   logic               build_phase_ff, build_phase_in;
   hks_pkg::state_type sift_return;

   // Where a finished sift goes back to
   assign sift_return = build_phase_ff ? hks_pkg::ST_BUILD_NEXT : hks_pkg::ST_REMOVE_NEXT;

   // Next state
   always_comb begin
      state_in       = state_ff;
      build_phase_in = build_phase_ff;
      unique case (state_ff)
         hks_pkg::ST_IDLE: begin
            if (req_valid && status.set_last) begin
               state_in = hks_pkg::ST_SETUP;
            end
         end
         hks_pkg::ST_SETUP: begin
            state_in       = hks_pkg::ST_BUILD_NEXT;
            build_phase_in = 1'b1;
         end
         hks_pkg::ST_BUILD_NEXT: begin
            if (status.bld_zero) begin
               state_in       = hks_pkg::ST_REMOVE_NEXT;
               build_phase_in = 1'b0;
            end else begin
               state_in = hks_pkg::ST_HELD_WAIT;
            end
         end
         hks_pkg::ST_REMOVE_NEXT: begin
            state_in = status.rem_zero ? hks_pkg::ST_READ_TOP : hks_pkg::ST_HELD_WAIT;
         end
         hks_pkg::ST_HELD_WAIT: state_in = hks_pkg::ST_SIFT_TEST;
         hks_pkg::ST_SIFT_TEST: begin
            state_in = status.kid_gt_last ? sift_return : hks_pkg::ST_CHILD_L;
         end
         hks_pkg::ST_CHILD_L: begin
            state_in = status.kid_lt_last ? hks_pkg::ST_CHILD_R : hks_pkg::ST_DECIDE;
         end
         hks_pkg::ST_CHILD_R: state_in = hks_pkg::ST_DECIDE;
         hks_pkg::ST_DECIDE: begin
            state_in = status.held_wins ? sift_return : hks_pkg::ST_SIFT_TEST;
         end
         hks_pkg::ST_READ_TOP: state_in = hks_pkg::ST_TOP_WAIT;
         hks_pkg::ST_TOP_WAIT: begin
            if (status.rsp_free) begin
               state_in = hks_pkg::ST_IDLE;
            end
         end
         default: state_in = hks_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hks_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         hks_pkg::ST_SETUP:       cmd.setup = 1'b1;
         hks_pkg::ST_BUILD_NEXT:  cmd.build_read = !status.bld_zero;
         hks_pkg::ST_REMOVE_NEXT: cmd.remove_read = !status.rem_zero;
         hks_pkg::ST_HELD_WAIT:   cmd.capture_held = 1'b1;
         hks_pkg::ST_SIFT_TEST: begin
            cmd.write_held = status.kid_gt_last;
            cmd.read_left  = !status.kid_gt_last;
         end
         hks_pkg::ST_CHILD_L: begin
            cmd.capture_left = 1'b1;
            cmd.read_right   = status.kid_lt_last;
         end
         hks_pkg::ST_CHILD_R: cmd.capture_right = status.right_better;
         hks_pkg::ST_DECIDE: begin
            cmd.write_held = status.held_wins;
            cmd.write_cand = !status.held_wins;
         end
         hks_pkg::ST_READ_TOP: cmd.read_top = 1'b1;
         hks_pkg::ST_TOP_WAIT: cmd.load_rsp = status.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= hks_pkg::ST_IDLE;
         build_phase_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         build_phase_ff <= build_phase_in;
      end
   end

   assign fsm_state = state_ff;

endmodule

@@ src/heap_kth_select.sv @@
// heap_kth_select: top level of the heap-based rank selector.
// Depends on hks_pkg, hks_ctrl and hks_datapath.
//
// Usage:
//  - csr_wr_en/csr_index/csr_wdata write element_count (index 0) and rank
//    (index 1) while the block is idle. Reset loads count 100, rank 10.
//  - req_* carries one signed value per transfer. Values fill the store one
//    per cycle; the transfer that brings the last value of the set starts
//    the selection, and req_ready stays low until it finishes.
//  - rsp_* carries one result per set: the value of the requested rank.
// Selection:
//  - Setup and read-out frame the sifts: count/2 for the build, one per
//    removal. Each sift compares the held value with one or two children
//    per level and stops when it wins or runs off the bottom of the heap.
//    The single read port of the store sets the pace of every step.
// Reset clears the fill count, the controller and the result valid; the
// store needs no clearing. If rsp_ready is low, the result holds in its
// output register; loading of the next set goes on meanwhile, and only the
// end of the next selection waits for the register to free up.
module heap_kth_select #(
   parameter int STORE_DEPTH = hks_pkg::DEFAULT_STORE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [hks_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hks_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [hks_pkg::VALUE_W-1:0]  req_sample_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [hks_pkg::VALUE_W-1:0]  rsp_selected_value
);

   hks_pkg::cmd_type    cmd;
   hks_pkg::status_type status;
   hks_pkg::state_type  fsm_state;

   hks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .fsm_state (fsm_state)
   );

   hks_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_sample_value   (req_sample_value),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_selected_value (rsp_selected_value),
      .cmd                (cmd),
      .status             (status)
   );

   // A result only appears out of the read-out state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(fsm_state == hks_pkg::ST_TOP_WAIT))
      else $error("result valid raised outside read-out");

   // The right child is read only when it lies inside the heap
   assert property (@(posedge clock) disable iff (reset)
      (fsm_state == hks_pkg::ST_CHILD_R) |-> $past(status.kid_lt_last))
      else $error("right child read beyond heap end");

   // A removal never runs on an empty heap
   assert property (@(posedge clock) disable iff (reset)
      (fsm_state == hks_pkg::ST_REMOVE_NEXT && !status.rem_zero) |->
         !status.heap_end_zero)
      else $error("removal with heap exhausted");

   // The last value of a set starts the selection
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.set_last) |=> (fsm_state == hks_pkg::ST_SETUP))
      else $error("set completed without starting selection");

endmodule
